// ===== rtl/shash_pkg.sv =====
// Shared types, constants and helpers for the SHA-256 stream hasher.
// Used by shash_sched, shash_round and sha256_stream_hasher_core; no dependencies.
package shash_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  // Input opcodes.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Control from the sequencer to the message window and the round unit.
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_in;
    logic       start;
    logic       step;
    logic [5:0] round_idx;
  } shash_ctl_t;

  localparam hash_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher top level: sequencer, chain value, length counter and digest output.
// Depends on shash_pkg, shash_sched and shash_round.
//
//   channel | ports                                        | direction
//   in      | in_valid, in_stall, in_opcode, in_data_byte  | bytes and finish in
//   out     | out_valid, out_stall, out_digest_word,       | eight digest words out
//           | out_word_index, out_last_word                |
//
// An absorbed byte shifts straight into the block buffer; the 64th byte of a block also starts
// the rounds of the shared round unit, followed by a feed-forward step.
// A finish shifts in 64 - fill padding bytes (128 - fill when fill is 56 or more),
// one per cycle, runs one or two compressions, then offers eight words.
// in_stall is high whenever the sequencer is not idle, including while words are offered.
// out_stall holds the current word; the block restarts its chain after the eighth transfer.
// Reset is synchronous and active low and loads the initial hash values.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import shash_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_FEED = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [5:0]  round_r, round_nxt;
  hash_t       chain_r, chain_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        pad_final_r, pad_final_nxt;
  logic [2:0]  idx_r, idx_nxt;

  shash_ctl_t  ctl;
  word_t       w_cur;
  hash_t       v;
  logic        in_xfer;
  logic        out_xfer;
  logic [63:0] len_bits;
  logic [2:0]  len_sel;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid & ~in_stall;
  assign out_valid = (state_r == ST_EMIT);
  assign out_xfer  = out_valid & ~out_stall;

  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_WORD);

  // Length bytes go out big-endian at block offsets 56 through 63.
  assign len_bits = {len_r, 3'b000};
  assign len_sel  = LAST_WORD - fill_r[2:0];
  assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

  always_comb begin
    if (pad_first_r) begin
      pad_byte = 8'h80;
    end else if (pad_final_r && (fill_r >= LEN_POS)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  shash_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  shash_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .chain (chain_r),
    .w_cur (w_cur),
    .v     (v)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    round_nxt     = round_r;
    chain_nxt     = chain_r;
    pad_act_nxt   = pad_act_r;
    pad_first_nxt = pad_first_r;
    pad_final_nxt = pad_final_r;
    idx_nxt       = idx_r;
    ctl           = '0;
    ctl.byte_in   = in_data_byte;
    ctl.round_idx = round_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_ABSORB) begin
            ctl.shift_byte = 1'b1;
            fill_nxt       = fill_r + 6'd1;
            len_nxt        = len_r + 61'd1;
            if (fill_r == LAST_POS) begin
              ctl.start = 1'b1;
              round_nxt = '0;
              state_nxt = ST_COMP;
            end
          end else begin
            pad_act_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            pad_final_nxt = 1'b0;
            state_nxt     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.byte_in    = pad_byte;
        fill_nxt       = fill_r + 6'd1;
        pad_first_nxt  = 1'b0;
        // The length fits behind the 0x80 marker only if the marker lands before offset 56.
        if (pad_first_r && (fill_r < LEN_POS)) begin
          pad_final_nxt = 1'b1;
        end
        if (fill_r == LAST_POS) begin
          ctl.start = 1'b1;
          round_nxt = '0;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_RND) begin
          state_nxt = ST_FEED;
        end
      end
      ST_FEED: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + v[i];
        end
        if (!pad_act_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_final_r) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          pad_final_nxt = 1'b1;
          state_nxt     = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            chain_nxt     = INIT_H;
            fill_nxt      = '0;
            len_nxt       = '0;
            pad_act_nxt   = 1'b0;
            pad_final_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      round_r     <= '0;
      chain_r     <= INIT_H;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      pad_final_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      round_r     <= round_nxt;
      chain_r     <= chain_nxt;
      pad_act_r   <= pad_act_nxt;
      pad_first_r <= pad_first_nxt;
      pad_final_r <= pad_final_nxt;
      idx_r       <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_full_block_compresses: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_opcode == OP_ABSORB) && (fill_r == LAST_POS)) |=>
    (state_r == ST_COMP) && (round_r == 6'd0))
    else $error("full block did not start compression");

  a_rounds_end_in_feed: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COMP) && (round_r == LAST_RND)) |=> (state_r == ST_FEED))
    else $error("compression did not end in feed-forward");

  a_emit_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pad_act_r && pad_final_r && (fill_r == 6'd0)))
    else $error("digest offered before the length block was compressed");

  a_restart_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_word) |=>
    ((state_r == ST_IDLE) && (len_r == 61'd0) && (chain_r == INIT_H)))
    else $error("block did not restart after the last digest word");
`endif

endmodule

// ===== rtl/shash_sched.sv =====
// Block buffer and message schedule window: bytes shift in, then one schedule word per round.
// Depends on shash_pkg.
module shash_sched (
  input  logic                   clk,
  input  shash_pkg::shash_ctl_t  ctl,
  output shash_pkg::word_t       w_cur
);
  import shash_pkg::*;

  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  word_t        w1;
  word_t        w9;
  word_t        w14;
  word_t        s0;
  word_t        s1;
  word_t        w_new;

  // Word j of the window sits at blk_r[511-32*j -: 32]; word 0 is the oldest.
  assign w_cur = blk_r[511:480];
  assign w1    = blk_r[479:448];
  assign w9    = blk_r[223:192];
  assign w14   = blk_r[63:32];

  assign s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign w_new = w_cur + s0 + w9 + s1;

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.shift_byte) begin
      blk_nxt = {blk_r[503:0], ctl.byte_in};
    end else if (ctl.step) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ===== rtl/shash_round.sv =====
// Working variables a..h and the shared compression round logic.
// Depends on shash_pkg.
module shash_round (
  input  logic                   clk,
  input  shash_pkg::shash_ctl_t  ctl,
  input  shash_pkg::hash_t       chain,
  input  shash_pkg::word_t       w_cur,
  output shash_pkg::hash_t       v
);
  import shash_pkg::*;

  hash_t v_r;
  hash_t v_nxt;
  word_t big0;
  word_t big1;
  word_t choose;
  word_t major;
  word_t t1;
  word_t t2;

  assign v = v_r;

  assign big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1     = v_r[7] + big1 + choose + round_k(ctl.round_idx) + w_cur;
  assign big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2     = big0 + major;

  always_comb begin
    v_nxt = v_r;
    if (ctl.start) begin
      v_nxt = chain;
    end else if (ctl.step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule
